// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/glr_pkg.sv
package glr_pkg;
   localparam int MAX_DEGREE_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DEG_W          = 7;
   localparam int X_W            = 32;
   localparam int VAL_W          = 64;
   localparam int NUM_W          = 128;

   // Register indexes.
   localparam logic CSR_DEGREE = 1'b0;
   localparam logic CSR_ALPHA  = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MULA = 7'b0000010,
      ST_MULB = 7'b0000100,
      ST_NORM = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_SAT  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;
endpackage

// File: rtl/core/generalized_laguerre_recurrence_unit.sv
// Channel   Ports                                      Handshake
// request   start, busy, req_sample_x                  start while not busy
// response  rsp_valid, rsp_poly_value, rsp_overflow_flag  one-cycle strobe
// config    csr_we, csr_index, csr_wdata               write when csr_we high
//
// busy stays high while a sample is worked on: n-1 recurrence steps at
// degree n >= 1, none at degree zero. Each step takes a setup step, four
// 32x32 partial products for each of the two products, a magnitude step,
// 128 restoring divide steps and a saturate step. The word is strobed in
// the first idle cycle, where a new start may already be taken. Reset is
// synchronous and clears the sequencer, the valid flag and the config registers; no stalls.
`include "assert_macros.svh"
module generalized_laguerre_recurrence_unit
   import glr_pkg::*;
#(
   parameter int MAX_DEGREE = MAX_DEGREE_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [X_W-1:0]   req_sample_x,
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_poly_value,
   output logic                    rsp_overflow_flag,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [X_W-1:0]          csr_wdata
);
   localparam int KW = DEG_W + 1;
   localparam logic [KW-1:0] MAXD = KW'(MAX_DEGREE);

   state_type state_ff, state_in;
   logic [DEG_W-1:0]       degree_ff;
   logic signed [X_W-1:0]  alpha_ff, x_ff;
   logic [KW-1:0]          k_ff, k_in, n_ff, n_in;
   logic [VAL_W-1:0]       lk_ff, lk_in, lkm1_ff, lkm1_in;
   logic [VAL_W-1:0]       opa_ff, opa_in, opb_ff, opb_in;
   logic                   nega_ff, nega_in;
   logic [3:0]             pp_ff, pp_in;
   logic [NUM_W-1:0]       acc_ff, acc_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [VAL_W-1:0]       rem_ff, rem_in;
   logic [6:0]             bit_ff, bit_in;
   logic                   neg_ff, neg_in, ovf_ff, ovf_in;
   logic                   valid_ff, valid_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         alpha_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DEGREE: degree_ff <= csr_wdata[DEG_W-1:0];
            CSR_ALPHA:  alpha_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Shared 32x32 multiplier on the current partial product.
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [NUM_W-1:0] pp_shift;
   assign mul_a = pp_ff[1] ? opa_ff[63:32] : opa_ff[31:0];
   assign mul_b = pp_ff[0] ? opb_ff[63:32] : opb_ff[31:0];
   assign mul_p = mul_a * mul_b;
   assign pp_shift = {64'd0, mul_p} << (7'(pp_ff[1] + pp_ff[0]) * 7'd32);

   // Recurrence coefficients, Q.FRAC_BITS, 64-bit signed.
   logic signed [VAL_W-1:0] coef_a, coef_b;
   logic [VAL_W-1:0] d_val;
   assign coef_a = (VAL_W'(2 * k_ff + 1) <<< FRAC_BITS) + VAL_W'(alpha_ff) - VAL_W'(x_ff);
   assign coef_b = (VAL_W'(k_ff) <<< FRAC_BITS) + VAL_W'(alpha_ff);
   assign d_val  = VAL_W'(k_ff + 1'b1) << FRAC_BITS;

   // First-order value from the sample being accepted.
   logic [VAL_W-1:0] l1_from_x;
   assign l1_from_x = (VAL_W'(1) << 32) +
      ((VAL_W'(alpha_ff) - VAL_W'(req_sample_x)) << (32 - FRAC_BITS));

   function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
      mag = v[VAL_W-1] ? (~v + 1'b1) : v;
   endfunction

   // Divider step.
   logic [VAL_W:0] rem_sh;
   logic           rem_ge;
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge = rem_sh >= {1'b0, d_val};

   logic [NUM_W-1:0] acc_next;
   assign acc_next = acc_ff + pp_shift;

   // Sequencer.
   always_comb begin
      state_in = state_ff; k_in = k_ff; n_in = n_ff; lk_in = lk_ff;
      lkm1_in = lkm1_ff; opa_in = opa_ff; opb_in = opb_ff; nega_in = nega_ff;
      pp_in = pp_ff; acc_in = acc_ff; num_in = num_ff; rem_in = rem_ff;
      bit_in = bit_ff; neg_in = neg_ff; ovf_in = ovf_ff; valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = (KW'(degree_ff) > MAXD) ? MAXD : KW'(degree_ff);
               ovf_in = 1'b0;
               lkm1_in = VAL_W'(1) << 32;
               k_in = KW'(1);
               state_in = ST_DONE;
            end
         end
         ST_MULA: begin
            // Product A * L(k), accumulated unsigned.
            acc_in = (pp_ff == 4'd0) ? pp_shift : acc_next;
            if (pp_ff == 4'd3) begin
               num_in = nega_ff ? ~acc_in + 1'b1 : acc_in;
               opa_in = mag(coef_b); opb_in = mag(lkm1_ff);
               nega_in = ~(coef_b[VAL_W-1] ^ lkm1_ff[VAL_W-1]);
               pp_in = 4'd0; state_in = ST_MULB;
            end else pp_in = pp_ff + 1'b1;
         end
         ST_MULB: begin
            // Subtract B * L(k-1): the sign flag is inverted for it.
            acc_in = (pp_ff == 4'd0) ? pp_shift : acc_next;
            if (pp_ff == 4'd3) begin
               num_in = num_ff + (nega_ff ? ~acc_in + 1'b1 : acc_in);
               state_in = ST_NORM;
            end else pp_in = pp_ff + 1'b1;
         end
         ST_NORM: begin
            neg_in = num_ff[NUM_W-1];
            num_in = num_ff[NUM_W-1] ? ~num_ff + 1'b1 : num_ff;
            rem_in = '0; bit_in = 7'd127; acc_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle, restoring.
            rem_in = rem_ge ? VAL_W'(rem_sh - {1'b0, d_val}) : rem_sh[VAL_W-1:0];
            acc_in = {acc_ff[NUM_W-2:0], rem_ge};
            num_in = {num_ff[NUM_W-2:0], 1'b0};
            if (bit_ff == 7'd0) state_in = ST_SAT;
            else bit_in = bit_ff - 1'b1;
         end
         ST_SAT: begin
            lkm1_in = lk_ff;
            if (neg_ff) begin
               if (acc_ff[NUM_W-1:VAL_W] != '0 || acc_ff[VAL_W-1:0] > {1'b1, 63'd0}) begin
                  ovf_in = 1'b1; lk_in = {1'b1, 63'd0};
               end else lk_in = ~acc_ff[VAL_W-1:0] + 1'b1;
            end else begin
               if (acc_ff[NUM_W-1:VAL_W] != '0 || acc_ff[VAL_W-1] != 1'b0) begin
                  ovf_in = 1'b1; lk_in = {1'b0, {63{1'b1}}};
               end else lk_in = acc_ff[VAL_W-1:0];
            end
            k_in = k_ff + 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Finish at degree zero or once k reaches n, else run one more step.
            if (n_ff == '0) begin
               lk_in = VAL_W'(1) << 32; valid_in = 1'b1; state_in = ST_IDLE;
            end else begin
               if (k_ff >= n_ff) begin
                  valid_in = 1'b1; state_in = ST_IDLE;
               end else begin
                  opa_in = mag(coef_a); opb_in = mag(lk_ff);
                  nega_in = coef_a[VAL_W-1] ^ lk_ff[VAL_W-1];
                  pp_in = 4'd0; state_in = ST_MULA;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // Seed L1 in the accept cycle.
      if (state_ff == ST_IDLE && start) lk_in = l1_from_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) x_ff <= req_sample_x;
      k_ff <= k_in; n_ff <= n_in; lk_ff <= lk_in; lkm1_ff <= lkm1_in;
      opa_ff <= opa_in; opb_ff <= opb_in; nega_ff <= nega_in; pp_ff <= pp_in;
      acc_ff <= acc_in; num_ff <= num_in; rem_ff <= rem_in; bit_ff <= bit_in;
      neg_ff <= neg_in; ovf_ff <= ovf_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_poly_value = lk_ff;
   assign rsp_overflow_flag = ovf_ff;

   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_valid_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_IMPLIES(a_one_hot, clock, reset, 1'b1, $onehot(state_ff))
endmodule
